// ===== hw/rtl/spg_pkg.sv =====
// Shared types, register indexes and arithmetic helpers for the servo pattern generator.
// Used by every module under hw/rtl; depends on nothing else.
package spg_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 24;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] REG_MODE         = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_POS_A        = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_POS_B        = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_POS_C        = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_STEP_SIZE    = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_CYCLE_LIMIT  = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_DWELL_TENTHS = 3'd6;
  localparam logic [CfgIndexWidth-1:0] REG_PERIOD_MS    = 3'd7;

  // Pattern modes.
  localparam logic [1:0] MODE_SWEEP = 2'd0;
  localparam logic [1:0] MODE_THREE = 2'd1;
  localparam logic [1:0] MODE_TWO   = 2'd2;
  localparam logic [1:0] MODE_FIXED = 2'd3;

  localparam logic [14:0] PULSE_MAX    = 15'd32767;
  localparam logic [12:0] COMPARE_MAX  = 13'd8191;
  localparam logic [23:0] TRIPS_MAX    = 24'hFFFFFF;
  localparam logic [17:0] DWELL_UNIT   = 18'd200000;
  localparam logic [10:0] PERIOD_SCALE = 11'd2000;
  // floor(x / 5) == (x * 26215) >> 17 for every 15-bit x.
  localparam logic [14:0] DIV5_RECIP   = 15'd26215;

  typedef struct packed {
    logic [1:0]  mode;
    logic [14:0] pos_a;
    logic [14:0] pos_b;
    logic [14:0] pos_c;
    logic [13:0] step_size;
    logic [12:0] step_div5;    // step_size / 5
    logic [23:0] cycle_limit;
    logic [27:0] dwell_limit;  // dwell_tenths * 200000
    logic [15:0] dwell_inc;    // period_ms * 2000 - 1, or zero for a zero period
  } cfg_t;

  // Packed so that compare_value lands in the lowest bits of the output beat.
  typedef struct packed {
    logic        moving_down;
    logic [1:0]  position_index;
    logic        finished;
    logic [23:0] cycles_done;
    logic [14:0] pulse_width;
    logic [12:0] compare_value;
  } result_t;

  function automatic logic [12:0] div5(input logic [14:0] x);
    logic [29:0] prod;
    prod = x * DIV5_RECIP;
    return prod[29:17];
  endfunction

endpackage

// ===== hw/rtl/spg_obuf.sv =====
// Two-entry result buffer between the pattern core and the output stream.
// Depends on spg_pkg for the result type.
module spg_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  spg_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output spg_pkg::result_t out_data
);
  import spg_pkg::*;

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // The fill count never passes the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result buffer count out of range");

  // A push never lands on a full buffer that is not draining.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("result buffer overflow");

endmodule

// ===== hw/rtl/spg_core.sv =====
// Pattern state and combinational next-state logic of the servo pattern generator.
// Depends on spg_pkg for the configuration and result types and the divide-by-five helper.
module spg_core (
  input  logic             clk,
  input  logic             rst,
  input  spg_pkg::cfg_t    cfg,
  input  logic             clear_trips,
  input  logic             adv,
  input  logic             update,
  output spg_pkg::result_t result
);
  import spg_pkg::*;

  logic        direction;
  logic [1:0]  slot;
  logic [27:0] dwell_acc;
  logic [14:0] pulse;
  logic [23:0] trips;
  logic [12:0] compare_hold;

  logic        direction_next;
  logic [1:0]  slot_next;
  logic [27:0] dwell_acc_next;
  logic [14:0] pulse_next;
  logic [23:0] trips_next;
  logic [12:0] compare_hold_next;

  logic        step;
  logic        limit_hit;
  logic [27:0] acc_sum;
  logic        elapsed;
  logic [23:0] trip_inc;
  logic [1:0]  slot_eff;
  logic        go;
  logic [14:0] go_target;
  logic [12:0] pulse_div5;
  logic [13:0] cmp_up;
  logic [15:0] pulse_up;

  assign step       = adv && update;
  assign limit_hit  = (cfg.cycle_limit != 24'd0) && (trips >= cfg.cycle_limit);
  assign acc_sum    = dwell_acc + {12'd0, cfg.dwell_inc};
  assign elapsed    = (acc_sum >= cfg.dwell_limit);
  assign trip_inc   = (trips == TRIPS_MAX) ? trips : trips + 24'd1;
  assign slot_eff   = (slot == 2'd2) ? 2'd0 : slot;
  assign pulse_div5 = div5(pulse);
  assign cmp_up     = {1'b0, pulse_div5} + {1'b0, cfg.step_div5};
  assign pulse_up   = {1'b0, pulse} + {2'b00, cfg.step_size};

  always_comb begin
    direction_next    = direction;
    slot_next         = slot;
    dwell_acc_next    = dwell_acc;
    pulse_next        = pulse;
    trips_next        = trips;
    compare_hold_next = compare_hold;
    go                = 1'b0;
    go_target         = cfg.pos_a;

    if (step) begin
      unique case (cfg.mode)
        MODE_SWEEP: begin
          if (!limit_hit) begin
            if (!direction) begin
              if (pulse < cfg.pos_b) begin
                compare_hold_next = cmp_up[13] ? COMPARE_MAX : cmp_up[12:0];
                pulse_next        = pulse_up[15] ? PULSE_MAX : pulse_up[14:0];
              end else begin
                direction_next = 1'b1;
              end
            end else begin
              if (pulse > cfg.pos_a) begin
                compare_hold_next = (pulse_div5 > cfg.step_div5) ?
                                    pulse_div5 - cfg.step_div5 : 13'd0;
                pulse_next        = (pulse > {1'b0, cfg.step_size}) ?
                                    pulse - {1'b0, cfg.step_size} : 15'd0;
              end else begin
                direction_next = 1'b0;
                trips_next     = trip_inc;
              end
            end
          end
        end
        MODE_THREE: begin
          if (!limit_hit) begin
            dwell_acc_next = elapsed ? 28'd0 : acc_sum;
            if (elapsed) begin
              if (!direction) begin
                case (slot)
                  2'd0: begin slot_next = 2'd1; go = 1'b1; go_target = cfg.pos_b; end
                  2'd1: begin slot_next = 2'd2; go = 1'b1; go_target = cfg.pos_c; end
                  2'd2: begin
                    direction_next = 1'b1;
                    slot_next      = 2'd1;
                    go             = 1'b1;
                    go_target      = cfg.pos_b;
                  end
                  default: ;
                endcase
              end else begin
                case (slot)
                  2'd0: begin
                    direction_next = 1'b0;
                    slot_next      = 2'd1;
                    go             = 1'b1;
                    go_target      = cfg.pos_b;
                  end
                  2'd1: begin
                    slot_next  = 2'd0;
                    go         = 1'b1;
                    go_target  = cfg.pos_a;
                    trips_next = trip_inc;
                  end
                  2'd2: begin slot_next = 2'd1; go = 1'b1; go_target = cfg.pos_b; end
                  default: ;
                endcase
              end
            end
          end
        end
        MODE_TWO: begin
          // Slot two has no meaning here and folds back to the first slot.
          slot_next = slot_eff;
          if (!limit_hit) begin
            dwell_acc_next = elapsed ? 28'd0 : acc_sum;
            if (elapsed) begin
              go = 1'b1;
              if (!direction) begin
                if (slot_eff == 2'd0) begin
                  slot_next = 2'd1;
                  go_target = cfg.pos_b;
                end else begin
                  direction_next = 1'b1;
                  slot_next      = 2'd0;
                  go_target      = cfg.pos_a;
                  trips_next     = trip_inc;
                end
              end else begin
                if (slot_eff == 2'd0) begin
                  direction_next = 1'b0;
                  slot_next      = 2'd1;
                  go_target      = cfg.pos_b;
                end else begin
                  slot_next = 2'd0;
                  go_target = cfg.pos_a;
                end
              end
            end
          end
        end
        MODE_FIXED: begin
          go        = 1'b1;
          go_target = cfg.pos_a;
        end
        default: ;
      endcase
    end

    if (go) begin
      compare_hold_next = div5(go_target);
      pulse_next        = go_target;
    end
  end

  always_comb begin
    result.compare_value  = compare_hold_next;
    result.pulse_width    = pulse_next;
    result.cycles_done    = trips_next;
    result.finished       = (cfg.cycle_limit != 24'd0) && (trips_next >= cfg.cycle_limit);
    result.position_index = slot_next;
    result.moving_down    = direction_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= 1'b0;
      slot         <= 2'd0;
      dwell_acc    <= 28'd0;
      pulse        <= 15'd15000;
      trips        <= 24'd0;
      compare_hold <= 13'd3000;
    end else begin
      if (adv) begin
        direction    <= direction_next;
        slot         <= slot_next;
        dwell_acc    <= dwell_acc_next;
        pulse        <= pulse_next;
        trips        <= trips_next;
        compare_hold <= compare_hold_next;
      end
      if (clear_trips) begin
        trips <= 24'd0;
      end
    end
  end

  // The slot code three is never produced.
  a_slot_range: assert property (@(posedge clk) disable iff (rst) slot != 2'd3)
    else $error("slot index reached an unused code");

  // Once the round-trip limit is hit, a tick leaves the trip count alone.
  a_frozen_trips: assert property (@(posedge clk) disable iff (rst)
    (step && limit_hit) |=> $stable(trips))
    else $error("trip count moved while the pattern was frozen");

  // After a running dwell tick the accumulator is either cleared or below its threshold.
  a_dwell_bound: assert property (@(posedge clk) disable iff (rst)
    (step && !limit_hit && (cfg.mode == MODE_THREE || cfg.mode == MODE_TWO))
      |=> (dwell_acc < cfg.dwell_limit || dwell_acc == 28'd0))
    else $error("dwell accumulator left above its threshold");

endmodule

// ===== hw/rtl/servo_pattern_generator.sv =====
// Top level of the servo pattern generator: stream ports, configuration registers and input stage.
// Depends on spg_pkg, spg_core and spg_obuf.
module servo_pattern_generator (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [spg_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [spg_pkg::CfgDataWidth-1:0]  cfg_data,
  // Period ticks in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] update, [7:1] zero
  // Pulse results out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [12:0] compare_value, [27:13] pulse_width,
                                      // [51:28] cycles_done, [52] finished,
                                      // [54:53] position_index, [55] moving_down
);
  // Every beat on the slave side is one PWM period tick, and each tick yields exactly one
  // result beat carrying the new compare value and pattern status. A tick with update low
  // leaves the pattern where it is and simply reports it again. The block takes one tick
  // per clock cycle while the result buffer has room: a tick is held in an input register,
  // the whole pattern step (sweep arithmetic, dwell accumulation, position sequencing) is
  // evaluated combinationally while it advances and written to the state registers and a
  // two-entry result buffer, from which its result beat leaves on the master side. The
  // rate is set by that state update, which every tick depends on. The result buffer lets
  // a tick be accepted while an earlier result still waits; ready drops only when the
  // buffer is full and a tick is already held. Configuration registers are written with
  // cfg_we, cfg_index and cfg_data; the user must write them only while no tick is in
  // flight, and the block does not enforce this. Writing the mode register also clears
  // the round-trip count. Step size, dwell time and period are converted to their
  // internal forms at write time.
  import spg_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  logic    in_update;
  logic    adv;
  logic    buf_full;
  logic    clear_trips;
  result_t core_result;
  result_t out_result;

  // Input stage: a tick moves on as soon as the result buffer has room.
  assign adv           = in_valid && !buf_full;
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_update <= s_axis_tdata[0];
    end
  end

  assign clear_trips = cfg_we && (cfg_index == REG_MODE);

  // Configuration registers, with the derived dwell and step terms computed on write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_SWEEP;
      cfg.pos_a       <= 15'd8000;
      cfg.pos_b       <= 15'd22000;
      cfg.pos_c       <= 15'd15000;
      cfg.step_size   <= 14'd100;
      cfg.step_div5   <= 13'd20;
      cfg.cycle_limit <= 24'd0;
      cfg.dwell_limit <= 28'd2000000;
      cfg.dwell_inc   <= 16'd39999;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:         cfg.mode        <= cfg_data[1:0];
        REG_POS_A:        cfg.pos_a       <= cfg_data[14:0];
        REG_POS_B:        cfg.pos_b       <= cfg_data[14:0];
        REG_POS_C:        cfg.pos_c       <= cfg_data[14:0];
        REG_STEP_SIZE: begin
          cfg.step_size <= cfg_data[13:0];
          cfg.step_div5 <= div5({1'b0, cfg_data[13:0]});
        end
        REG_CYCLE_LIMIT:  cfg.cycle_limit <= cfg_data[23:0];
        REG_DWELL_TENTHS: cfg.dwell_limit <= 28'(cfg_data[9:0]) * 28'(DWELL_UNIT);
        REG_PERIOD_MS: begin
          // A zero period adds nothing to the dwell accumulator.
          if (cfg_data[4:0] == 5'd0) begin
            cfg.dwell_inc <= 16'd0;
          end else begin
            cfg.dwell_inc <= 16'(cfg_data[4:0]) * 16'(PERIOD_SCALE) - 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  spg_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .clear_trips (clear_trips),
    .adv         (adv),
    .update      (in_update),
    .result      (core_result)
  );

  spg_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (adv),
    .push_data (core_result),
    .full      (buf_full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_result)
  );

  assign m_axis_tdata = out_result;

  // The input stage only advances into a buffer with room.
  a_adv_room: assert property (@(posedge clk) disable iff (rst) adv |-> !buf_full)
    else $error("input stage advanced into a full result buffer");

  // A held tick that cannot advance keeps the slave side stalled.
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && buf_full) |-> !s_axis_tready)
    else $error("tick accepted while the held tick was stalled");

  // A tick that advances leaves a result beat waiting on the master side.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !buf_full) |=> m_axis_tvalid)
    else $error("advanced tick produced no result beat");

endmodule
